// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  // Default screen geometry
  localparam int unsigned COLUMNS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT    = 25;

  // Fixed payload widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned COL_OUT_W = 7;

  // Character codes and reset attribute
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  // Command codes; the fourth code is a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // an item is taken this cycle
    logic put_en;      // write a character or take a newline
    logic read_en;     // read one cell
    logic home_en;     // home the cursor at the start of a clear
    logic sweep_en;    // write one blank cell at the sweep address
    logic sweep_init;  // sweep uses the reset attribute
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;  // sweep address is the last cell
  } dp_stat_t;

endpackage

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [tcw_pkg::CMD_W-1:0]          cmd_i,
  input  tcw_pkg::dp_stat_t                  stat_i,
  output tcw_pkg::dp_ctrl_t                  ctrl_o,
  output logic                               busy_o,
  output logic                               done_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_INIT  = 3'b010,
    ST_CLEAR = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   accept;

  // Decode the incoming command
  always_comb begin
    accept              = start_i && (state_q == ST_IDLE);
    ctrl_o              = '0;
    ctrl_o.accept       = accept;
    ctrl_o.put_en       = accept && (cmd_i == tcw_pkg::CMD_PUT);
    ctrl_o.read_en      = accept && (cmd_i == tcw_pkg::CMD_READ);
    ctrl_o.home_en      = accept && (cmd_i == tcw_pkg::CMD_CLEAR);
    ctrl_o.sweep_en     = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    ctrl_o.sweep_init   = (state_q == ST_INIT);
  end

  // Advance the state machine
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == tcw_pkg::CMD_CLEAR) begin
            state_d = ST_CLEAR;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      ST_INIT: begin
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  // End of a clear sweep gives one result and frees the block
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && stat_i.sweep_last) |=> (done_q && state_q == ST_IDLE))
    else $error("clear sweep ended without a result");

  // No result while the reset sweep runs
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |=> !done_q)
    else $error("result during reset sweep");
`endif

endmodule

// ===== rtl/tcw_datapath.sv =====
module tcw_datapath #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tcw_pkg::dp_ctrl_t                  ctrl_i,
  output tcw_pkg::dp_stat_t                  stat_o,
  input  logic [tcw_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]        cell_index_i,
  input  logic                               attr_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]         attr_i,
  output logic [tcw_pkg::CELL_W-1:0]         cell_word_o,
  output logic [tcw_pkg::ROW_OUT_W-1:0]      cursor_row_o,
  output logic [tcw_pkg::COL_OUT_W-1:0]      cursor_col_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned IW    = tcw_pkg::INDEX_W;

  logic [CW-1:0]                   col_q, col_d;
  logic [RW-1:0]                   row_q, row_d;
  logic [AW-1:0]                   base_q, base_d;
  logic [AW-1:0]                   sweep_q;
  logic [tcw_pkg::ATTR_W-1:0]      attr_q;
  logic                            rd_valid_q;
  logic [tcw_pkg::CELL_W-1:0]      rdata_q;
  logic [tcw_pkg::CELL_W-1:0]      mem_q [CELLS];

  logic                            is_newline;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [tcw_pkg::CELL_W-1:0]      wr_data;
  logic [AW+IW-1:0]                idx_wide;
  logic [AW-1:0]                   rd_addr;
  logic                            rd_in_range;
  logic [tcw_pkg::ATTR_W-1:0]      fill_attr;

  assign is_newline = (char_code_i == tcw_pkg::NEWLINE_CODE);
  assign stat_o.sweep_last = (sweep_q == AW'(CELLS - 1));

  // Cursor update: home on clear; advance, wrap column into next row, wrap row to top
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (ctrl_i.home_en) begin
      col_d  = '0;
      row_d  = '0;
      base_d = '0;
    end else if (ctrl_i.put_en) begin
      if (!is_newline && (col_q != CW'(COLUMNS - 1))) begin
        col_d = col_q + CW'(1);
      end else begin
        col_d = '0;
        if (row_q == RW'(ROWS - 1)) begin
          row_d  = '0;
          base_d = '0;
        end else begin
          row_d  = row_q + RW'(1);
          base_d = base_q + AW'(COLUMNS);
        end
      end
    end
  end

  // Pick the write port source: sweep or character put
  always_comb begin
    fill_attr = ctrl_i.sweep_init ? tcw_pkg::RESET_ATTR : attr_q;
    if (ctrl_i.sweep_en) begin
      wr_en   = 1'b1;
      wr_addr = sweep_q;
      wr_data = {fill_attr, tcw_pkg::SPACE_CODE};
    end else begin
      wr_en   = ctrl_i.put_en && !is_newline;
      wr_addr = base_q + AW'(col_q);
      wr_data = {attr_q, char_code_i};
    end
  end

  // Read address and range check
  assign idx_wide    = (AW + IW)'(cell_index_i);
  assign rd_addr     = idx_wide[AW-1:0];
  assign rd_in_range = (32'(cell_index_i) < 32'(CELLS));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      base_q     <= '0;
      sweep_q    <= '0;
      attr_q     <= tcw_pkg::RESET_ATTR;
      rd_valid_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
      if (ctrl_i.sweep_en) begin
        sweep_q <= stat_o.sweep_last ? '0 : sweep_q + AW'(1);
      end
      if (attr_we_i) begin
        attr_q <= attr_i;
      end
      if (ctrl_i.accept) begin
        rd_valid_q <= ctrl_i.read_en && rd_in_range;
      end
    end
  end

  // Screen store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.read_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign cell_word_o  = rd_valid_q ? rdata_q : '0;
  assign cursor_row_o = tcw_pkg::ROW_OUT_W'(row_q);
  assign cursor_col_o = tcw_pkg::COL_OUT_W'(col_q);

`ifndef NO_ASSERTIONS
  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= RW'(ROWS - 1)) && (col_q <= CW'(COLUMNS - 1)))
    else $error("cursor off screen");

  // Row base tracks the cursor row
  a_base_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(base_q) == 32'(row_q) * 32'(COLUMNS))
    else $error("row base out of step with cursor row");
`endif

endmodule

// ===== rtl/text_console_cell_writer.sv =====
// Text console cell writer: a ROWS x COLUMNS store of 16-bit cells
// (attribute in the high byte, character in the low byte) with a cursor.
// Commands: start_i with busy_o low takes cmd_i, char_code_i, cell_index_i.
//   put (0)   writes char_code_i at the cursor and advances it; a newline
//             code moves the cursor to column 0 of the next row.
//   clear (1) blanks every cell with a space in the current attribute and
//             homes the cursor.
//   read (2)  returns the cell at cell_index_i; out of range reads give 0.
// Each command gives one result, marked by done_o for a single cycle, with
// cell_word_o and the cursor position after the command. There is no way
// to hold a result off; it must be taken in that cycle.
// Put, read and the unused code take one cycle each: the result appears in
// the cycle after the transfer and a new command may be taken every cycle.
// Clear walks the store one cell per cycle on the write port, so it keeps
// busy_o high through the walk and gives its result in the cycle after the last cell.
// After reset the same walk fills the store with blank cells in attribute
// 0x07 (busy_o high, no result). text_attribute_i is written when
// text_attribute_we_i is high and applies from the next command.
module text_console_cell_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [tcw_pkg::CMD_W-1:0]          cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]        cell_index_i,
  input  logic                               text_attribute_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]         text_attribute_i,
  output logic                               done_o,
  output logic [tcw_pkg::CELL_W-1:0]         cell_word_o,
  output logic [tcw_pkg::ROW_OUT_W-1:0]      cursor_row_out_o,
  output logic [tcw_pkg::COL_OUT_W-1:0]      cursor_col_out_o
);

  tcw_pkg::dp_ctrl_t ctrl;
  tcw_pkg::dp_stat_t stat;

  // Sequence commands and the store sweep
  tcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Cursor, attribute and screen store
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_we_i    (text_attribute_we_i),
    .attr_i       (text_attribute_i),
    .cell_word_o  (cell_word_o),
    .cursor_row_o (cursor_row_out_o),
    .cursor_col_o (cursor_col_out_o)
  );

endmodule

// ===== dv/tb_text_console_cell_writer.sv =====
`timescale 1ns / 1ps

module tb_text_console_cell_writer;

  localparam int COLS  = tcw_pkg::COLUMNS_DEFAULT;
  localparam int LINES = tcw_pkg::ROWS_DEFAULT;
  localparam int CELLS = COLS * LINES;
  localparam int IDLE_LIMIT = 12000;

  // Payload widths
  localparam int CMD_W     = tcw_pkg::CMD_W;
  localparam int CHAR_W    = tcw_pkg::CHAR_W;
  localparam int ATTR_W    = tcw_pkg::ATTR_W;
  localparam int INDEX_W   = tcw_pkg::INDEX_W;
  localparam int CELL_W    = tcw_pkg::CELL_W;
  localparam int ROW_OUT_W = tcw_pkg::ROW_OUT_W;
  localparam int COL_OUT_W = tcw_pkg::COL_OUT_W;

  // The fourth command code does nothing
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef enum logic [1:0] {
    ITEM_CMD,
    ITEM_ATTR,
    ITEM_DRAIN
  } item_kind_e;

  typedef struct {
    item_kind_e          kind;
    logic [CMD_W-1:0]    cmd;
    logic [CHAR_W-1:0]   code;
    logic [INDEX_W-1:0]  index;
    logic [ATTR_W-1:0]   attr;
    bit                  calm;
  } console_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]    word;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } console_out_t;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    cmd_d = '0;
  logic [CHAR_W-1:0]   code_d = '0;
  logic [INDEX_W-1:0]  index_d = '0;
  logic                attr_we = 1'b0;
  logic [ATTR_W-1:0]   attr_d = '0;
  logic                done;
  logic [CELL_W-1:0]   cell_word;
  logic [ROW_OUT_W-1:0] out_row;
  logic [COL_OUT_W-1:0] out_col;

  console_item_t pending_cmds[$];
  console_out_t  due_outputs[$];

  // Screen predictor state
  logic [CELL_W-1:0]    model_cells [CELLS];
  logic [ROW_OUT_W-1:0] model_row;
  logic [COL_OUT_W-1:0] model_col;
  logic [ATTR_W-1:0]    model_attr;

  int unsigned sent_count = 0;
  int unsigned got_count  = 0;
  int unsigned errors     = 0;
  int unsigned gap_left   = 0;
  int unsigned quiet      = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_put = 0, n_newline = 0, n_clear = 0, n_read = 0, n_read_out = 0;
  int unsigned n_none = 0, n_attr = 0;

  text_console_cell_writer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .start_i            (start),
    .busy_o             (busy),
    .cmd_i              (cmd_d),
    .char_code_i        (code_d),
    .cell_index_i       (index_d),
    .text_attribute_we_i(attr_we),
    .text_attribute_i   (attr_d),
    .done_o             (done),
    .cell_word_o        (cell_word),
    .cursor_row_out_o   (out_row),
    .cursor_col_out_o   (out_col)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Queue builders
  task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch,
                         input logic [INDEX_W-1:0] idx, input bit calm);
    console_item_t it;
    it.kind = ITEM_CMD; it.cmd = c; it.code = ch; it.index = idx; it.attr = '0;
    it.calm = calm;
    pending_cmds.push_back(it);
  endtask

  task automatic add_ctrl(input item_kind_e k, input logic [ATTR_W-1:0] a);
    console_item_t it;
    it.kind = k; it.cmd = CMD_NONE; it.code = '0; it.index = '0; it.attr = a;
    it.calm = 1'b1;
    pending_cmds.push_back(it);
  endtask

  // Driver: hold each command until transferred, pause for register writes
  always @(posedge clk_i) begin : cmd_driver
    console_item_t head;
    int unsigned   quiet_n;
    if (!rst_n) begin
      start    <= 1'b0;
      attr_we  <= 1'b0;
      gap_left <= 0;
      quiet    <= 0;
    end else begin
      quiet_n = (!start && !busy && sent_count == got_count) ? quiet + 1 : 0;
      if (start && !busy) begin
        void'(pending_cmds.pop_front());
        sent_count <= sent_count + 1;
      end
      if (start && busy) begin
        attr_we <= 1'b0;
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        attr_we  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() == 0) begin
        start   <= 1'b0;
        attr_we <= 1'b0;
      end else begin
        head = pending_cmds[0];
        if (head.kind == ITEM_CMD) begin
          attr_we <= 1'b0;
          if (!head.calm && $urandom_range(0, 11) == 0) begin
            start    <= 1'b0;
            gap_left <= $urandom_range(0, 16);
          end else begin
            start   <= 1'b1;
            cmd_d   <= head.cmd;
            code_d  <= head.code;
            index_d <= head.index;
          end
        end else begin
          // Wait for every result and a short settle before touching the register
          start <= 1'b0;
          if (quiet_n >= 3) begin
            attr_we <= (head.kind == ITEM_ATTR);
            if (head.kind == ITEM_ATTR) attr_d <= head.attr;
            void'(pending_cmds.pop_front());
            quiet_n = 0;
          end else begin
            attr_we <= 1'b0;
          end
        end
      end
      quiet <= quiet_n;
    end
  end

  // Monitor: check each result, then predict the command transferred now
  always @(posedge clk_i) begin : console_monitor
    console_out_t         got, want;
    logic [INDEX_W-1:0]   pos;
    logic                 bump_row;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++)
        model_cells[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
      model_row  = '0;
      model_col  = '0;
      model_attr = tcw_pkg::RESET_ATTR;
      got_count <= 0;
    end else begin
      if (done) begin
        got_count <= got_count + 1;
        got = '{cell_word, out_row, out_col};
        if (due_outputs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result: cell %h row %0d col %0d",
                     $realtime, got.word, got.row, got.col);
        end else begin
          want = due_outputs.pop_front();
          if (got.word !== want.word || got.row !== want.row || got.col !== want.col) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] mismatch: cell %h/%h row %0d/%0d col %0d/%0d (exp/act)",
                       $realtime, want.word, got.word, want.row, got.row,
                       want.col, got.col);
          end
        end
      end

      if (attr_we) begin
        model_attr = attr_d;
        n_attr++;
      end

      if (start && !busy) begin
        want.word = '0;
        bump_row  = 1'b0;
        case (cmd_d)
          tcw_pkg::CMD_PUT: begin
            n_put++;
            if (code_d == tcw_pkg::NEWLINE_CODE) begin
              n_newline++;
              model_col = '0;
              bump_row  = 1'b1;
            end else begin
              pos = INDEX_W'(int'(model_row) * COLS + int'(model_col));
              model_cells[pos] = {model_attr, code_d};
              if (int'(model_col) == COLS - 1) begin
                model_col = '0;
                bump_row  = 1'b1;
              end else begin
                model_col = model_col + COL_OUT_W'(1);
              end
            end
            if (bump_row)
              model_row = (int'(model_row) == LINES - 1) ? '0 : model_row + ROW_OUT_W'(1);
          end
          tcw_pkg::CMD_CLEAR: begin
            n_clear++;
            for (int i = 0; i < CELLS; i++) model_cells[i] = {model_attr, tcw_pkg::SPACE_CODE};
            model_row = '0;
            model_col = '0;
          end
          tcw_pkg::CMD_READ: begin
            n_read++;
            if (int'(index_d) < CELLS) want.word = model_cells[index_d];
            else n_read_out++;
          end
          default: n_none++;
        endcase
        want.row = model_row;
        want.col = model_col;
        due_outputs.push_back(want);
      end
    end
  end

  // Watchdog on cycles with no command transfer and no result
  always @(posedge clk_i) begin : idle_watchdog
    if (rst_n) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d idle cycles", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [ATTR_W-1:0]  phase_attr [6];
    logic [INDEX_W-1:0] idx;
    int unsigned        r, sub;
    bit                 calm;

    // Directed: reset contents, range edges, character extremes, no-op, attribute writes, clear
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd0, 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd1999, 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd2000, 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd2047, 1'b0);
    add_cmd(tcw_pkg::CMD_PUT, 8'h41, INDEX_W'($urandom), 1'b0);
    add_cmd(tcw_pkg::CMD_PUT, 8'h00, INDEX_W'($urandom), 1'b0);
    add_cmd(tcw_pkg::CMD_PUT, 8'hFF, INDEX_W'($urandom), 1'b0);
    add_cmd(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, INDEX_W'($urandom), 1'b0);
    add_cmd(CMD_NONE, 8'hFF, 11'h7FF, 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd0, 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd1, 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd2, 1'b0);
    add_cmd(tcw_pkg::CMD_PUT, 8'h42, INDEX_W'($urandom), 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd80, 1'b0);
    add_ctrl(ITEM_ATTR, 8'hFF);
    add_cmd(tcw_pkg::CMD_PUT, 8'h7E, INDEX_W'($urandom), 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd81, 1'b0);
    add_cmd(tcw_pkg::CMD_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom), 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd0, 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd1999, 1'b0);
    add_ctrl(ITEM_ATTR, 8'h00);
    add_cmd(tcw_pkg::CMD_PUT, 8'h00, INDEX_W'($urandom), 1'b0);
    add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), 11'd0, 1'b0);
    add_ctrl(ITEM_DRAIN, 8'h00);

    // Random phases, each under its own attribute; two phases insert no random gaps
    phase_attr[0] = 8'h00;
    phase_attr[1] = ATTR_W'($urandom);
    phase_attr[2] = 8'hFF;
    phase_attr[3] = tcw_pkg::RESET_ATTR;
    phase_attr[4] = ATTR_W'($urandom);
    phase_attr[5] = ATTR_W'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      add_ctrl(ITEM_ATTR, phase_attr[ph]);
      calm = (ph == 2 || ph == 5);
      for (int n = 0; n < 321; n++) begin
        r = $urandom_range(0, 999);
        if (n == 160 && ph == 1) add_ctrl(ITEM_DRAIN, 8'h00);
        if (r < 3) begin
          add_cmd(tcw_pkg::CMD_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom), calm);
        end else if (r < 25) begin
          add_cmd(CMD_NONE, CHAR_W'($urandom), INDEX_W'($urandom), calm);
        end else if (r < 260) begin
          sub = $urandom_range(0, 9);
          if (sub < 5)      idx = INDEX_W'($urandom_range(0, 399));
          else if (sub < 9) idx = INDEX_W'($urandom_range(0, CELLS - 1));
          else              idx = INDEX_W'($urandom_range(CELLS, 2047));
          add_cmd(tcw_pkg::CMD_READ, CHAR_W'($urandom), idx, calm);
        end else if ($urandom_range(0, 7) == 0) begin
          add_cmd(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, INDEX_W'($urandom), calm);
        end else begin
          add_cmd(tcw_pkg::CMD_PUT, CHAR_W'($urandom), INDEX_W'($urandom), calm);
        end
      end
    end

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // Drain: all commands transferred and every result back, then settle
    @(posedge clk_i);
    while (pending_cmds.size() != 0 || start || sent_count != got_count)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    errors += due_outputs.size();

    $display("Covered %0d puts (%0d newlines), %0d reads (%0d out of range), %0d clears",
             n_put, n_newline, n_read, n_read_out, n_clear);
    $display("plus %0d no-op commands under %0d attribute settings; %0d failures",
             n_none, n_attr, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
